// File: hw/rtl/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, character constants and alphabet mapping for the Base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_D0    = 8'h30;

   localparam logic [5:0] IDX_LOWER = 6'd26;
   localparam logic [5:0] IDX_DIGIT = 6'd52;
   localparam logic [5:0] IDX_62    = 6'd62;
   localparam logic [5:0] IDX_63    = 6'd63;

   // one group of up to three bytes, left aligned, zero filled
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  nbytes;   // 1..3
      logic        last;
      logic        url_safe;
   } grp_type;

   function automatic logic [7:0] map_char(input logic [5:0] idx, input logic url);
      logic [7:0] c;
      c = CHAR_UA + {2'b00, idx};
      if (idx >= IDX_LOWER) c = CHAR_LA + {2'b00, idx} - {2'b00, IDX_LOWER};
      if (idx >= IDX_DIGIT) c = CHAR_D0 + {2'b00, idx} - {2'b00, IDX_DIGIT};
      if (idx == IDX_62)    c = url ? CHAR_MINUS : CHAR_PLUS;
      if (idx == IDX_63)    c = url ? CHAR_UNDER : CHAR_SLASH;
      return c;
   endfunction

endpackage

// File: hw/rtl/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, collects them into groups of three and pushes a
// finished or flushed group to the queue.
// ----------------------------------------------------------------------------
module b64e_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 url_safe,
   input  logic                 push_ready,
   output logic                 push_valid,
   output b64e_pkg::grp_type    push_grp
);

   logic [1:0]  held_ff, held_in;
   logic [15:0] pend_ff, pend_in;
   logic        take;
   logic        flush;

   assign req_tready = push_ready;
   assign take       = req_tvalid && req_tready;
   assign flush      = (held_ff == 2'd2) || req_tlast;
   assign push_valid = take && flush;

   always_comb begin
      push_grp.last     = req_tlast;
      push_grp.url_safe = url_safe;
      push_grp.nbytes   = held_ff + 2'd1;
      case (held_ff)
         2'd0:    push_grp.bits = {req_tdata, 16'h0000};
         2'd1:    push_grp.bits = {pend_ff[7:0], req_tdata, 8'h00};
         default: push_grp.bits = {pend_ff, req_tdata};
      endcase
   end

   always_comb begin
      held_in = held_ff;
      pend_in = pend_ff;
      if (take) begin
         if (flush) begin
            held_in = 2'd0;
            pend_in = 16'h0000;
         end else begin
            held_in = held_ff + 2'd1;
            pend_in = {pend_ff[7:0], req_tdata};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         pend_ff <= 16'h0000;
      end else begin
         held_ff <= held_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// File: hw/rtl/b64e_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64e_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  b64e_pkg::grp_type    push_grp,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output b64e_pkg::grp_type    pop_grp
);

   b64e_pkg::grp_type                entry_ff [b64e_pkg::QDEPTH];
   logic [b64e_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [b64e_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [b64e_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = (cnt_ff != b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_grp    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_grp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Takes one group from the queue and sends its four characters, one per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module b64e_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  b64e_pkg::grp_type    pop_grp,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);

   b64e_pkg::grp_type grp_ff, grp_in;
   logic              busy_ff, busy_in;
   logic [1:0]        beat_ff, beat_in;
   logic              ovalid_ff, ovalid_in;
   logic [7:0]        ochar_ff, ochar_in;
   logic              olast_ff, olast_in;
   logic              out_free;
   logic              emit;
   logic              done;
   logic [5:0]        idx;

   assign out_free  = !ovalid_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   assign done      = emit && (beat_ff == 2'd3);
   assign pop_ready = !busy_ff || done;

   always_comb begin
      case (beat_ff)
         2'd0:    idx = grp_ff.bits[23:18];
         2'd1:    idx = grp_ff.bits[17:12];
         2'd2:    idx = grp_ff.bits[11:6];
         default: idx = grp_ff.bits[5:0];
      endcase
   end

   always_comb begin
      grp_in    = grp_ff;
      busy_in   = busy_ff;
      beat_in   = beat_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      ochar_in  = ochar_ff;
      olast_in  = olast_ff;
      if (emit) begin
         ovalid_in = 1'b1;
         ochar_in  = (beat_ff > grp_ff.nbytes) ? b64e_pkg::CHAR_PAD
                     : b64e_pkg::map_char(idx, grp_ff.url_safe);
         olast_in  = grp_ff.last && (beat_ff == 2'd3);
         beat_in   = beat_ff + 2'd1;
         if (done) busy_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         grp_in  = pop_grp;
         busy_in = 1'b1;
         beat_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff   <= grp_in;
      ochar_ff <= ochar_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         beat_ff   <= 2'd0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         beat_ff   <= beat_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = ochar_ff;
   assign rsp_tlast  = olast_ff;

endmodule

// File: hw/rtl/base64_stream_encoder_core.sv
// The group that a request completes or closes passes through the group queue,
// group register and output register; its characters leave one per cycle
// unless rsp_tready stalls them. Requests are taken one per cycle while the
// group queue has room; the single-character output path sets the sustained rate.
// Reset (synchronous, active high) clears pending bytes, queue, output stage
// and the alphabet select; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming Base64 encoder: bytes in, alphabet characters and padding out,
// with a selectable URL-safe alphabet.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,   // url_safe
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] data_byte
   input  logic       req_tlast,     // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_char
   output logic       rsp_tlast      // last_char
);

   logic              url_safe_ff, url_safe_in;
   logic              push_valid;
   logic              push_ready;
   b64e_pkg::grp_type push_grp;
   logic              pop_valid;
   logic              pop_ready;
   b64e_pkg::grp_type pop_grp;

   assign url_safe_in = csr_wr_en ? csr_wr_data : url_safe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         url_safe_ff <= 1'b0;
      end else begin
         url_safe_ff <= url_safe_in;
      end
   end

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .url_safe   (url_safe_ff),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_grp   (push_grp)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_grp   (push_grp),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_grp    (pop_grp)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_grp    (pop_grp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/b64e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the encoder output stream.
// ----------------------------------------------------------------------------
module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h5A) ||
                     (rsp_tdata >= 8'h61 && rsp_tdata <= 8'h7A) ||
                     (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
                     rsp_tdata == 8'h2B || rsp_tdata == 8'h2F ||
                     rsp_tdata == 8'h2D || rsp_tdata == 8'h5F ||
                     rsp_tdata == 8'h3D)
      else $error("response is not an alphabet or pad character");

   a_pad_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata == 8'h3D && !rsp_tlast |=>
         !rsp_tvalid || rsp_tdata == 8'h3D)
      else $error("pad followed by a data character");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
